[hw/rtl/dsrm_pkg.sv]
`timescale 1ns / 1ps

package dsrm_pkg;

  localparam int unsigned TrackW  = 10;
  localparam int unsigned SectorW = 6;
  localparam int unsigned StepW   = 11;
  localparam int unsigned AngleW  = 15;
  localparam int unsigned RemW    = 7;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SecOutW = 7;
  localparam int unsigned CmpW    = 17;

  localparam int unsigned FracBits    = 8;
  localparam int unsigned SectorCount = 64;
  localparam int unsigned Turn        = SectorCount << FracBits;
  localparam int unsigned TrackStep   = 25;

  // Exact for every 10-bit distance: floor(d * DivMul / 2^DivShift) == d / TrackStep.
  localparam int unsigned DivShift = 17;
  localparam int unsigned DivMul   = ((1 << DivShift) + TrackStep - 1) / TrackStep;
  localparam int unsigned ProdW    = 23;

  localparam logic [StepW-1:0] RotationStepReset = 11'd983;
  localparam logic [SumW-1:0]  SumMax            = '1;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeSeek = 2'd1,
    ModeWait = 2'd2
  } mode_e;

  typedef struct packed {
    logic               req_valid;
    logic [TrackW-1:0]  track;
    logic [SectorW-1:0] sector;
  } item_t;

  typedef struct packed {
    logic [TrackW-1:0]  track;
    logic [SectorW-1:0] sector;
    logic [SumW-1:0]    arrival;
  } req_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    mode_e               mode;
    logic [TrackW-1:0]   head;
    logic [SecOutW-1:0]  angle_sector;
    logic [CountW-1:0]   queue_count;
    logic                overflow;
    logic                dispatched;
    logic [SumW-1:0]     seek_total;
    logic [SumW-1:0]     latency_total;
    logic [SumW-1:0]     wait_total;
  } result_t;

endpackage

[hw/rtl/dsrm_front.sv]
`timescale 1ns / 1ps

module dsrm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dsrm_pkg::item_t in_item_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output dsrm_pkg::item_t item_o
);

  dsrm_pkg::item_t slot0_q, slot1_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot0_q;
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && cnt_q == 2'd1) begin
        slot0_q <= in_item_i;
      end else begin
        slot0_q <= slot1_q;
      end
      if (push && cnt_q == 2'd2) begin
        slot1_q <= in_item_i;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= in_item_i;
      end else begin
        slot1_q <= in_item_i;
      end
    end
  end

endmodule

[hw/rtl/dsrm_req_fifo.sv]
`timescale 1ns / 1ps

module dsrm_req_fifo #(
  parameter int unsigned QUEUE_SLOTS = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         pop_i,
  input  dsrm_pkg::req_entry_t         wdata_i,
  output dsrm_pkg::req_entry_t         head_o,
  output logic [$clog2(QUEUE_SLOTS)-1:0] count_o,
  output dsrm_pkg::fifo_stat_t         stat_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_SLOTS);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_SLOTS - 1);

  dsrm_pkg::req_entry_t mem [QUEUE_SLOTS];
  dsrm_pkg::req_entry_t rdata_q;
  logic [PtrW-1:0]      rptr_q, rptr_d, wptr_q, wptr_d, count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == LastSlot);
  assign count_o      = count_q;

  // An empty queue hands the incoming entry straight through.
  assign head_o = stat_o.empty ? wdata_i : rdata_q;

  always_comb begin
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    count_d = count_q;
    if (pop_i) begin
      rptr_d = (rptr_q == LastSlot) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i) begin
      wptr_d = (wptr_q == LastSlot) ? '0 : wptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + PtrW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= wdata_i;
    end
    if (push_i && wptr_q == rptr_d) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[rptr_d];
    end
  end

endmodule

[hw/rtl/dsrm_back.sv]
`timescale 1ns / 1ps

module dsrm_back #(
  parameter int unsigned QUEUE_SLOTS = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dsrm_pkg::StepW-1:0]     cfg_wdata_i,
  input  logic                           item_valid_i,
  output logic                           item_ready_o,
  input  dsrm_pkg::item_t                item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dsrm_pkg::result_t              res_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_SLOTS);

  logic [dsrm_pkg::StepW-1:0]   step_q;
  dsrm_pkg::mode_e              mode_q, mode_d;
  logic [dsrm_pkg::TrackW-1:0]  head_q, head_d, goal_track_q, goal_track_d;
  logic [dsrm_pkg::SectorW-1:0] goal_sector_q, goal_sector_d;
  logic [dsrm_pkg::RemW-1:0]    rem_q, rem_d;
  logic [dsrm_pkg::AngleW-1:0]  angle_q, angle_d;
  logic [dsrm_pkg::SumW-1:0]    tick_q, seek_q, seek_d, lat_q, lat_d, wait_q, wait_d;
  logic                         out_valid_q;
  dsrm_pkg::result_t            res_q, res_d;

  logic                         fire, push, pop, ovf;
  dsrm_pkg::req_entry_t         wdata, head_entry;
  logic [PtrW-1:0]              fifo_count, count_after;
  dsrm_pkg::fifo_stat_t         stat;

  logic [dsrm_pkg::AngleW-1:0]  angle_add;
  logic [dsrm_pkg::CmpW-1:0]    g_c, a_c, s_c, turn_c;
  logic                         hit;
  logic [dsrm_pkg::TrackW-1:0]  track_gap;
  logic [dsrm_pkg::ProdW-1:0]   prod;
  logic [dsrm_pkg::SumW:0]      wait_sum;
  logic [dsrm_pkg::SumW-1:0]    wait_delta;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign res_o        = res_q;

  assign wdata.track   = item_i.track;
  assign wdata.sector  = item_i.sector;
  assign wdata.arrival = tick_q;

  assign push = fire && item_i.req_valid && !stat.full;
  assign ovf  = item_i.req_valid && stat.full;

  dsrm_req_fifo #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .wdata_i (wdata),
    .head_o  (head_entry),
    .count_o (fifo_count),
    .stat_o  (stat)
  );

  always_comb begin
    mode_d        = mode_q;
    head_d        = head_q;
    goal_track_d  = goal_track_q;
    goal_sector_d = goal_sector_q;
    rem_d         = rem_q;
    seek_d        = seek_q;
    lat_d         = lat_q;
    wait_d        = wait_q;
    pop           = 1'b0;
    hit           = 1'b0;

    angle_add = angle_q + dsrm_pkg::AngleW'(step_q);
    if (angle_add > dsrm_pkg::AngleW'(dsrm_pkg::Turn)) begin
      angle_d = angle_add - dsrm_pkg::AngleW'(dsrm_pkg::Turn);
    end else begin
      angle_d = angle_add;
    end

    if (mode_q == dsrm_pkg::ModeSeek) begin
      if (seek_q != dsrm_pkg::SumMax) begin
        seek_d = seek_q + 32'd1;
      end
      if (rem_q <= dsrm_pkg::RemW'(1)) begin
        rem_d  = '0;
        mode_d = dsrm_pkg::ModeWait;
        head_d = goal_track_q;
      end else begin
        rem_d = rem_q - dsrm_pkg::RemW'(1);
        if (head_q > goal_track_q) begin
          head_d = head_q - dsrm_pkg::TrackW'(dsrm_pkg::TrackStep);
        end else begin
          head_d = head_q + dsrm_pkg::TrackW'(dsrm_pkg::TrackStep);
        end
      end
    end

    g_c    = dsrm_pkg::CmpW'(goal_sector_q) << dsrm_pkg::FracBits;
    a_c    = dsrm_pkg::CmpW'(angle_d);
    s_c    = dsrm_pkg::CmpW'(step_q);
    turn_c = dsrm_pkg::CmpW'(dsrm_pkg::Turn);
    if (mode_d == dsrm_pkg::ModeWait) begin
      if (g_c < s_c && a_c >= s_c) begin
        hit = (a_c <= g_c + turn_c) && (g_c + turn_c <= a_c + s_c);
      end else begin
        hit = (a_c <= g_c) && (g_c <= a_c + s_c);
      end
      if (hit) begin
        mode_d = dsrm_pkg::ModeIdle;
      end
      if (lat_q != dsrm_pkg::SumMax) begin
        lat_d = lat_q + 32'd1;
      end
    end

    // The distance is measured from the head position after this tick's seek step.
    if (head_entry.track > head_d) begin
      track_gap = head_entry.track - head_d;
    end else begin
      track_gap = head_d - head_entry.track;
    end
    prod       = dsrm_pkg::ProdW'(track_gap) * dsrm_pkg::ProdW'(dsrm_pkg::DivMul);
    wait_delta = tick_q - head_entry.arrival;
    wait_sum   = {1'b0, wait_q} + {1'b0, wait_delta};
    if (mode_d != dsrm_pkg::ModeSeek && mode_d != dsrm_pkg::ModeWait &&
        (!stat.empty || push)) begin
      pop           = fire;
      rem_d         = dsrm_pkg::RemW'(prod >> dsrm_pkg::DivShift);
      goal_track_d  = head_entry.track;
      goal_sector_d = head_entry.sector;
      mode_d        = dsrm_pkg::ModeSeek;
      wait_d        = wait_sum[dsrm_pkg::SumW] ? dsrm_pkg::SumMax
                                               : wait_sum[dsrm_pkg::SumW-1:0];
    end

    if (push && !pop) begin
      count_after = fifo_count + PtrW'(1);
    end else if (pop && !push) begin
      count_after = fifo_count - PtrW'(1);
    end else begin
      count_after = fifo_count;
    end

    res_d.mode          = mode_d;
    res_d.head          = head_d;
    res_d.angle_sector  = angle_d[dsrm_pkg::AngleW-1:dsrm_pkg::FracBits];
    res_d.queue_count   = dsrm_pkg::CountW'(count_after);
    res_d.overflow      = ovf;
    res_d.dispatched    = pop;
    res_d.seek_total    = seek_d;
    res_d.latency_total = lat_d;
    res_d.wait_total    = wait_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= dsrm_pkg::RotationStepReset;
      mode_q        <= dsrm_pkg::ModeIdle;
      head_q        <= '0;
      goal_track_q  <= '0;
      goal_sector_q <= '0;
      rem_q         <= '0;
      angle_q       <= '0;
      tick_q        <= '0;
      seek_q        <= '0;
      lat_q         <= '0;
      wait_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (fire) begin
        mode_q        <= mode_d;
        head_q        <= head_d;
        goal_track_q  <= goal_track_d;
        goal_sector_q <= goal_sector_d;
        rem_q         <= rem_d;
        angle_q       <= angle_d;
        tick_q        <= tick_q + 32'd1;
        seek_q        <= seek_d;
        lat_q         <= lat_d;
        wait_q        <= wait_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

[hw/rtl/disk_seek_rotation_model_core.sv]
`timescale 1ns / 1ps

// Disk timing model that advances one millisecond tick per transfer on the input channel and
// returns one result transfer per tick with the mode, head track, platter angle, queue fill,
// overflow and dispatch flags and the three saturating totals. It takes one tick per clock
// cycle while the output is not held back; a tick passes a two-entry input queue and then the
// tick engine's output register before its result appears. Requests wait in a ring of
// QUEUE_SLOTS entries (QUEUE_SLOTS-1 usable) held in a memory with a registered read port,
// and an empty ring passes an arriving request straight to dispatch. There is no clearing
// pass after reset. The rotation step register must be written only while no tick is in
// flight.
module disk_seek_rotation_model_core #(
  parameter int unsigned QUEUE_SLOTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        request_valid_i,
  input  logic [9:0]  request_track_i,
  input  logic [5:0]  request_sector_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  disk_mode_o,
  output logic [9:0]  head_track_o,
  output logic [6:0]  angle_sector_o,
  output logic [6:0]  queue_count_o,
  output logic        overflow_o,
  output logic        dispatched_o,
  output logic [31:0] seek_total_o,
  output logic [31:0] latency_total_o,
  output logic [31:0] wait_total_o
);

  dsrm_pkg::item_t   in_item, item;
  logic              item_valid, item_ready;
  dsrm_pkg::result_t res;

  assign in_item.req_valid = request_valid_i;
  assign in_item.track     = request_track_i;
  assign in_item.sector    = request_sector_i;

  dsrm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  dsrm_back #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign disk_mode_o     = res.mode;
  assign head_track_o    = res.head;
  assign angle_sector_o  = res.angle_sector;
  assign queue_count_o   = res.queue_count;
  assign overflow_o      = res.overflow;
  assign dispatched_o    = res.dispatched;
  assign seek_total_o    = res.seek_total;
  assign latency_total_o = res.latency_total;
  assign wait_total_o    = res.wait_total;

endmodule
